[rtl/core/voxel_chunk_slot_table_assert.svh]
// Assertion macros shared by the voxel chunk slot table RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef VOXEL_CHUNK_SLOT_TABLE_ASSERT_SVH
`define VOXEL_CHUNK_SLOT_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VCST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("voxel_chunk_slot_table: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VCST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("voxel_chunk_slot_table: assertion failed");

`endif

[rtl/core/vcst_pkg.sv]
// Types and constants of the voxel chunk slot table.
// No dependencies; used by voxel_chunk_slot_table.
`timescale 1ns / 1ps

package vcst_pkg;

  // Field widths fixed by the word format.
  localparam int COORD_W = 16;   // chunk coordinate held in a slot
  localparam int WORLD_W = 24;   // world block x and z
  localparam int DIST_W  = 25;   // signed chunk distance along one axis
  localparam int SQ_W    = 48;   // square of a distance, magnitude only

  // Configuration register indexes (byte address bit 2).
  localparam logic REG_RENDER_DISTANCE = 1'b0;
  localparam logic REG_AIR_VALUE       = 1'b1;

  localparam logic [3:0]  RENDER_RESET = 4'd4;
  localparam logic [15:0] AIR_RESET    = 16'd0;
  localparam logic [3:0]  CNT_MAX      = 4'd15;

  typedef enum logic [1:0] {
    REQ_MAP    = 2'd0,
    REQ_READ   = 2'd1,
    REQ_WRITE  = 2'd2,
    REQ_UNLOAD = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_HEIGHT   = 2'd1,
    STAT_UNLOADED = 2'd2,
    STAT_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH,
    ST_MEM
  } state_e;

endpackage

[rtl/core/voxel_chunk_slot_table.sv]
// Voxel chunk slot table: top level with sequencer, slot scan and shared squarer.
// Depends on vcst_pkg, vcst_ram and voxel_chunk_slot_table_assert.svh.
`timescale 1ns / 1ps
`include "voxel_chunk_slot_table_assert.svh"

// How to use this block.
// A request word is taken at a rising edge where start is high and busy is low.
// The block then works on that word alone and holds busy high until it is done.
// Every request gives one result word: done_o is high for exactly one cycle and
// the result ports are valid in that cycle. The receiver cannot stall the block,
// so the word must be taken in that cycle. A new request may be started in the
// same cycle in which done_o is high.
// From the accepting edge a request passes through the slot scan, the drain
// state and the finish state; unload requests stay in the drain state while the
// squarer empties, reads that hit add the block store read state, and reads or
// writes with a height out of range go straight to the finish state. Slot
// coordinates live in a small RAM read one entry per cycle during the scan, and
// unload requests pass each slot through the single shared squarer twice
// (x distance, then z distance).
// Configuration sits on an APB-style port, render_distance at byte address 0
// and air_value at byte address 4; the user must write it only while the block
// is idle, as the block itself does not enforce this. Reset frees every slot and
// loads the register reset values; slot coordinates (used only for valid slots)
// and the block store are not cleared, so unwritten block words read undefined.

module voxel_chunk_slot_table #(
  parameter int SLOTS   = 8,
  parameter int CHUNK_W = 16,
  parameter int CHUNK_H = 64,
  parameter int CHUNK_D = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request channel.
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type_i,
  input  logic signed [15:0] chunk_x_i,
  input  logic signed [15:0] chunk_z_i,
  input  logic signed [23:0] world_x_i,
  input  logic signed [15:0] world_y_i,
  input  logic signed [23:0] world_z_i,
  input  logic [15:0]        write_value_i,
  // Result channel.
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [15:0]        read_value_o,
  output logic [2:0]         slot_index_o,
  output logic [3:0]         removed_count_o,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Derived geometry. Chunk sizes are powers of two, so floor division is an
  // arithmetic shift and the floor modulo is the low bits.
  localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LX_W        = $clog2(CHUNK_W);
  localparam int Y_W         = $clog2(CHUNK_H);
  localparam int LZ_W        = $clog2(CHUNK_D);
  localparam int BS_AW       = SLOT_W + LZ_W + Y_W + LX_W;
  localparam int BS_DEPTH    = SLOTS * CHUNK_W * CHUNK_H * CHUNK_D;
  localparam int CRD_DW      = 2 * vcst_pkg::COORD_W;
  localparam int IDX_EXT_W   = (SLOT_W > 3) ? SLOT_W : 3;
  localparam int WX_PAD      = vcst_pkg::WORLD_W - vcst_pkg::COORD_W;
  localparam int DX_PAD      = vcst_pkg::DIST_W - vcst_pkg::COORD_W;
  localparam int DW_PAD      = vcst_pkg::DIST_W - vcst_pkg::WORLD_W;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [3:0]  render_q;
  logic [15:0] air_q;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      render_q <= vcst_pkg::RENDER_RESET;
      air_q    <= vcst_pkg::AIR_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == vcst_pkg::REG_RENDER_DISTANCE) begin
        render_q <= pwdata[3:0];
      end else begin
        air_q <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == vcst_pkg::REG_AIR_VALUE) ? {16'd0, air_q} : {28'd0, render_q};

  // ---------------------------------------------------------------------------
  // Request capture.
  // ---------------------------------------------------------------------------
  vcst_pkg::state_e state_q, state_d;
  vcst_pkg::req_e   req_q, req_in;

  logic                accept;
  logic                hbad_d, hbad_q;
  logic signed [23:0]  key_x_d, key_z_d, key_x_q, key_z_q;
  logic [LX_W-1:0]     lx_q;
  logic [LZ_W-1:0]     lz_q;
  logic [Y_W-1:0]      wy_q;
  logic [15:0]         wv_q;

  assign busy   = (state_q != vcst_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign req_in = vcst_pkg::req_e'(req_type_i);

  // Height check only matters for block reads and writes.
  always_comb begin
    hbad_d = ((req_in == vcst_pkg::REQ_READ) || (req_in == vcst_pkg::REQ_WRITE)) &&
             (world_y_i[15] || (world_y_i[14:0] >= 15'(CHUNK_H)));
    if (req_in == vcst_pkg::REQ_MAP) begin
      key_x_d = {{WX_PAD{chunk_x_i[15]}}, chunk_x_i};
      key_z_d = {{WX_PAD{chunk_z_i[15]}}, chunk_z_i};
    end else begin
      key_x_d = world_x_i >>> LX_W;
      key_z_d = world_z_i >>> LZ_W;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q  <= vcst_pkg::REQ_MAP;
      hbad_q <= 1'b0;
    end else if (accept) begin
      req_q  <= req_in;
      hbad_q <= hbad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_x_q <= key_x_d;
      key_z_q <= key_z_d;
      lx_q    <= world_x_i[LX_W-1:0];
      lz_q    <= world_z_i[LZ_W-1:0];
      wy_q    <= world_y_i[Y_W-1:0];
      wv_q    <= write_value_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Slot scan. One slot coordinate read is issued per cycle (two per slot for
  // unload requests); the registered read data is compared (or, for unload requests, squared) in the following cycle.
  // ---------------------------------------------------------------------------
  logic              scan_active;
  logic              last_issue;
  logic [SLOT_W-1:0] issue_idx_q;
  logic              issue_ph_q;
  logic              rd_vld_q, rd_ph_q;
  logic [SLOT_W-1:0] rd_idx_q;
  logic [SLOTS-1:0]  slot_valid_q;
  logic              claim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_idx_q <= '0;
      issue_ph_q  <= 1'b0;
    end else if (accept) begin
      issue_idx_q <= '0;
      issue_ph_q  <= 1'b0;
    end else if (scan_active) begin
      if ((req_q == vcst_pkg::REQ_UNLOAD) && !issue_ph_q) begin
        issue_ph_q <= 1'b1;
      end else begin
        issue_ph_q  <= 1'b0;
        issue_idx_q <= issue_idx_q + SLOT_W'(1);
      end
    end
  end

  assign last_issue = (issue_idx_q == SLOT_W'(SLOTS - 1)) &&
                      ((req_q != vcst_pkg::REQ_UNLOAD) || issue_ph_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      rd_ph_q  <= 1'b0;
    end else begin
      rd_vld_q <= scan_active;
      rd_idx_q <= issue_idx_q;
      rd_ph_q  <= issue_ph_q;
    end
  end

  // Slot coordinate store: x in the low half, z in the high half.
  logic [SLOT_W-1:0] free_idx_q;
  logic [SLOT_W-1:0] crd_addr;
  logic [CRD_DW-1:0] crd_rdata;
  logic [15:0]       slot_x, slot_z;

  assign crd_addr = scan_active ? issue_idx_q : free_idx_q;

  vcst_ram #(
    .WIDTH  (CRD_DW),
    .DEPTH  (SLOTS),
    .ADDR_W (SLOT_W)
  ) u_coord_ram (
    .clk_i   (clk_i),
    .re_i    (scan_active),
    .we_i    (claim),
    .addr_i  (crd_addr),
    .wdata_i ({key_z_q[15:0], key_x_q[15:0]}),
    .rdata_o (crd_rdata)
  );

  assign slot_x = crd_rdata[15:0];
  assign slot_z = crd_rdata[CRD_DW-1:16];

  // Match and first-free search for map, read and write requests.
  logic              slot_match;
  logic              hit_q, free_q;
  logic [SLOT_W-1:0] hit_idx_q;

  assign slot_match = slot_valid_q[rd_idx_q] &&
                      ({{WX_PAD{slot_x[15]}}, slot_x} == key_x_q) &&
                      ({{WX_PAD{slot_z[15]}}, slot_z} == key_z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
    end else if (accept) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (rd_vld_q && (req_q != vcst_pkg::REQ_UNLOAD)) begin
      if (slot_match && !hit_q) begin
        hit_q     <= 1'b1;
        hit_idx_q <= rd_idx_q;
      end
      if (!slot_valid_q[rd_idx_q] && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= rd_idx_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared squarer for unload requests. The x distance is squared in the first
  // phase of a slot and held; the z square joins it in the second phase and
  // the sum is compared with the squared render distance.
  // ---------------------------------------------------------------------------
  logic signed [vcst_pkg::DIST_W-1:0]   dx, dz, sq_op;
  logic signed [2*vcst_pkg::DIST_W-1:0] sq_full;
  logic [vcst_pkg::SQ_W-1:0]            prod_q, px_q;
  logic [vcst_pkg::SQ_W:0]              dist_sum;
  logic [7:0]                           r2;
  logic                                 prod_vld_q, prod_ph_q;
  logic [SLOT_W-1:0]                    prod_idx_q;
  logic                                 drop;
  logic [3:0]                           rm_cnt_q;

  always_comb begin
    dx = {{DX_PAD{slot_x[15]}}, slot_x} - {{DW_PAD{key_x_q[23]}}, key_x_q};
    dz = {{DX_PAD{slot_z[15]}}, slot_z} - {{DW_PAD{key_z_q[23]}}, key_z_q};
    sq_op   = rd_ph_q ? dz : dx;
    sq_full = sq_op * sq_op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      prod_ph_q  <= 1'b0;
      prod_idx_q <= '0;
    end else begin
      prod_vld_q <= rd_vld_q && (req_q == vcst_pkg::REQ_UNLOAD);
      prod_ph_q  <= rd_ph_q;
      prod_idx_q <= rd_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= sq_full[vcst_pkg::SQ_W-1:0];
    if (prod_vld_q && !prod_ph_q) begin
      px_q <= prod_q;
    end
  end

  assign r2       = {4'd0, render_q} * {4'd0, render_q};
  assign dist_sum = {1'b0, px_q} + {1'b0, prod_q};
  assign drop     = prod_vld_q && prod_ph_q && slot_valid_q[prod_idx_q] &&
                    (dist_sum > (vcst_pkg::SQ_W + 1)'(r2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rm_cnt_q <= '0;
    end else if (accept) begin
      rm_cnt_q <= '0;
    end else if (drop && (rm_cnt_q != vcst_pkg::CNT_MAX)) begin
      rm_cnt_q <= rm_cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else begin
      if (claim) begin
        slot_valid_q[free_idx_q] <= 1'b1;
      end
      if (drop) begin
        slot_valid_q[prod_idx_q] <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Block store. Word address is slot, local z, height and local x packed
  // from the top bit down.
  // ---------------------------------------------------------------------------
  logic             bs_re, bs_we;
  logic [15:0]      bs_rdata;
  logic [BS_AW-1:0] bs_addr;

  assign bs_addr = {hit_idx_q, lz_q, wy_q, lx_q};

  vcst_ram #(
    .WIDTH  (16),
    .DEPTH  (BS_DEPTH),
    .ADDR_W (BS_AW)
  ) u_block_ram (
    .clk_i   (clk_i),
    .re_i    (bs_re),
    .we_i    (bs_we),
    .addr_i  (bs_addr),
    .wdata_i (wv_q),
    .rdata_o (bs_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  logic                 drain_q, drain_d;
  logic                 res_load;
  vcst_pkg::status_e    res_status;
  logic [15:0]          res_rv;
  logic [SLOT_W-1:0]    res_slot;
  logic [3:0]           res_removed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vcst_pkg::ST_IDLE;
      drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      drain_q <= drain_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    drain_d     = drain_q;
    scan_active = 1'b0;
    claim       = 1'b0;
    bs_re       = 1'b0;
    bs_we       = 1'b0;
    res_load    = 1'b0;
    res_status  = vcst_pkg::STAT_OK;
    res_rv      = '0;
    res_slot    = '0;
    res_removed = '0;
    case (state_q)
      vcst_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = hbad_d ? vcst_pkg::ST_FINISH : vcst_pkg::ST_SCAN;
        end
      end
      vcst_pkg::ST_SCAN: begin
        scan_active = 1'b1;
        if (last_issue) begin
          state_d = vcst_pkg::ST_DRAIN;
          drain_d = (req_q == vcst_pkg::REQ_UNLOAD);
        end
      end
      vcst_pkg::ST_DRAIN: begin
        if (drain_q) begin
          drain_d = 1'b0;
        end else begin
          state_d = vcst_pkg::ST_FINISH;
        end
      end
      vcst_pkg::ST_FINISH: begin
        res_load = 1'b1;
        state_d  = vcst_pkg::ST_IDLE;
        case (req_q)
          vcst_pkg::REQ_MAP: begin
            if (hit_q) begin
              res_slot = hit_idx_q;
            end else if (free_q) begin
              claim    = 1'b1;
              res_slot = free_idx_q;
            end else begin
              res_status = vcst_pkg::STAT_FULL;
            end
          end
          vcst_pkg::REQ_READ: begin
            if (hbad_q) begin
              res_status = vcst_pkg::STAT_HEIGHT;
              res_rv     = air_q;
            end else if (!hit_q) begin
              res_status = vcst_pkg::STAT_UNLOADED;
              res_rv     = air_q;
            end else begin
              // Hit: fetch the word, the result goes out after the read.
              res_load = 1'b0;
              bs_re    = 1'b1;
              state_d  = vcst_pkg::ST_MEM;
            end
          end
          vcst_pkg::REQ_WRITE: begin
            if (hbad_q) begin
              res_status = vcst_pkg::STAT_HEIGHT;
            end else if (!hit_q) begin
              res_status = vcst_pkg::STAT_UNLOADED;
            end else begin
              bs_we = 1'b1;
            end
          end
          vcst_pkg::REQ_UNLOAD: begin
            res_removed = rm_cnt_q;
          end
          default: begin
            res_status = vcst_pkg::STAT_OK;
          end
        endcase
      end
      vcst_pkg::ST_MEM: begin
        res_load = 1'b1;
        res_rv   = bs_rdata;
        state_d  = vcst_pkg::ST_IDLE;
      end
      default: begin
        state_d = vcst_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result registers. done_q is a one-cycle strobe.
  // ---------------------------------------------------------------------------
  logic                 done_q;
  vcst_pkg::status_e    status_q;
  logic [15:0]          rv_q;
  logic [2:0]           slot_q;
  logic [3:0]           removed_q;
  logic [IDX_EXT_W-1:0] slot_ext;

  // Slot numbers wider than the port are reported modulo eight.
  assign slot_ext = IDX_EXT_W'(res_slot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      status_q  <= res_status;
      rv_q      <= res_rv;
      slot_q    <= slot_ext[2:0];
      removed_q <= res_removed;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign read_value_o    = rv_q;
  assign slot_index_o    = slot_q;
  assign removed_count_o = removed_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `VCST_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, accept, busy)
  `VCST_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_q, !busy)
  `VCST_ASSERT_IMP(a_bs_single_port, clk_i, rst_ni, bs_we, !bs_re && hit_q && !hbad_q)
  `VCST_ASSERT_IMP(a_removed_unload, clk_i, rst_ni, done_q && (req_q != vcst_pkg::REQ_UNLOAD), removed_q == 4'd0)

endmodule

[rtl/core/vcst_ram.sv]
// Single-port synchronous RAM with registered read data.
// No dependencies; holds the slot coordinates and the block store.
`timescale 1ns / 1ps

module vcst_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              re_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
